// ----- rtl/dfst_pkg.sv -----
// Shared types, constants and the control-store program of the DFS spanning-tree block.
// Used by every other file of the block but dfst_ram; depends on nothing.
package dfst_pkg;

    localparam int VERTICES_DEF    = 64;
    localparam int STACK_DEPTH_DEF = 4096;
    localparam int VW              = 6;       // vertex field width
    localparam int CNT_W           = 7;       // vertex_count width
    localparam logic [CNT_W-1:0] VCOUNT_RST = 7'd64;

    localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
    localparam logic [1:0] CMD_RUN      = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    typedef struct packed {
        logic [1:0]    command;
        logic [VW-1:0] from_vertex;
        logic [VW-1:0] to_vertex;
        logic          both_ways;
    } t_cmd;

    typedef struct packed {
        logic [VW-1:0] parent_vertex;
        logic          has_parent;
        logic [VW-1:0] child_vertex;
        logic          bad_start;
        logic          last;
    } t_res;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_FETCH,
        OP_ADD_RD_F,
        OP_ADD_WR_F,
        OP_ADD_RD_T,
        OP_ADD_WR_T,
        OP_CLEAR,
        OP_TEST,
        OP_START,
        OP_POP,
        OP_CHECK,
        OP_RD_ROW,
        OP_LOAD_ROW,
        OP_PUSH,
        OP_FINISH,
        OP_BAD
    } t_op;

    typedef logic [3:0] t_pc;

    localparam t_pc PC_FETCH    = 4'd0;
    localparam t_pc PC_ADD_RD_F = 4'd1;
    localparam t_pc PC_ADD_WR_F = 4'd2;
    localparam t_pc PC_ADD_RD_T = 4'd3;
    localparam t_pc PC_ADD_WR_T = 4'd4;
    localparam t_pc PC_CLEAR    = 4'd5;
    localparam t_pc PC_TEST     = 4'd6;
    localparam t_pc PC_START    = 4'd7;
    localparam t_pc PC_POP      = 4'd8;
    localparam t_pc PC_CHECK    = 4'd9;
    localparam t_pc PC_RD_ROW   = 4'd10;
    localparam t_pc PC_LOAD_ROW = 4'd11;
    localparam t_pc PC_PUSH     = 4'd12;
    localparam t_pc PC_FINISH   = 4'd13;
    localparam t_pc PC_BAD      = 4'd14;

    typedef struct packed {
        t_op op;
        t_pc target;
    } t_uword;

    // datapath -> sequencer
    typedef struct packed {
        logic       hold;
        logic       jump;
        logic [1:0] command;
    } t_status;

    // control store: a taken jump goes to target, otherwise to the next step
    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        case (pc)
            PC_FETCH:    w = '{op: OP_FETCH,    target: PC_FETCH};
            PC_ADD_RD_F: w = '{op: OP_ADD_RD_F, target: PC_FETCH};
            PC_ADD_WR_F: w = '{op: OP_ADD_WR_F, target: PC_FETCH};
            PC_ADD_RD_T: w = '{op: OP_ADD_RD_T, target: PC_FETCH};
            PC_ADD_WR_T: w = '{op: OP_ADD_WR_T, target: PC_FETCH};
            PC_CLEAR:    w = '{op: OP_CLEAR,    target: PC_FETCH};
            PC_TEST:     w = '{op: OP_TEST,     target: PC_BAD};
            PC_START:    w = '{op: OP_START,    target: PC_RD_ROW};
            PC_POP:      w = '{op: OP_POP,      target: PC_FINISH};
            PC_CHECK:    w = '{op: OP_CHECK,    target: PC_POP};
            PC_RD_ROW:   w = '{op: OP_RD_ROW,   target: PC_FETCH};
            PC_LOAD_ROW: w = '{op: OP_LOAD_ROW, target: PC_FETCH};
            PC_PUSH:     w = '{op: OP_PUSH,     target: PC_POP};
            PC_FINISH:   w = '{op: OP_FINISH,   target: PC_FETCH};
            PC_BAD:      w = '{op: OP_BAD,      target: PC_FETCH};
            default:     w = '{op: OP_FETCH,    target: PC_FETCH};
        endcase
        return w;
    endfunction

    function automatic t_pc dispatch(logic [1:0] command);
        t_pc pc;
        case (command)
            CMD_ADD_EDGE: pc = PC_ADD_RD_F;
            CMD_RUN:      pc = PC_TEST;
            CMD_CLEAR:    pc = PC_CLEAR;
            default:      pc = PC_FETCH;
        endcase
        return pc;
    endfunction

endpackage

// ----- rtl/dfst_if.sv -----
// Valid/ready stream interfaces for the command and result channels.
// Depends on dfst_pkg for the payload types.
interface dfst_cmd_if;
    import dfst_pkg::*;
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dfst_res_if;
    import dfst_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/dfst_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module dfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/dfst_seq.sv -----
// Microcode sequencer: step counter, control store lookup, dispatch and conditional jumps.
// Depends on dfst_pkg for the program and the control/status types.
module dfst_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dfst_pkg::t_status i_status,
    output dfst_pkg::t_op    o_op
);
    import dfst_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword uw;

    assign uw   = ucode(r_pc);
    assign o_op = uw.op;

    always_comb begin
        if (i_status.hold) begin
            n_pc = r_pc;
        end else if (uw.op == OP_FETCH) begin
            n_pc = dispatch(i_status.command);
        end else if (i_status.jump) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PC_BAD)
        else $error("step counter left the program");
endmodule

// ----- rtl/dfst_dp.sv -----
// Datapath: adjacency row memory with valid bits, pair stack memory, visited set,
// neighbor scan and the result hold/output registers. Depends on dfst_pkg, dfst_if, dfst_ram.
module dfst_dp #(
    parameter int VERTICES    = dfst_pkg::VERTICES_DEF,
    parameter int STACK_DEPTH = dfst_pkg::STACK_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [dfst_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  dfst_pkg::t_op             i_op,
    output dfst_pkg::t_status         o_status,
    dfst_cmd_if.sink                  i_cmd,
    dfst_res_if.source                o_res
);
    import dfst_pkg::*;

    localparam int ROWS = (VERTICES < (1 << VW)) ? VERTICES : (1 << VW);
    localparam int AW   = $clog2(ROWS);
    localparam int SW   = $clog2(STACK_DEPTH);
    localparam int FW   = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0] r_vcount;
    logic [CNT_W-1:0] r_cnt;
    logic [ROWS-1:0]  r_visited;
    logic [ROWS-1:0]  r_row_vld;
    logic             r_rd_vld;
    logic [FW-1:0]    r_fill;
    logic             r_pend_v;
    logic             r_out_v;
    t_cmd             r_in;
    logic [AW-1:0]    r_cur;
    logic [ROWS-1:0]  r_scan;
    t_res             r_pend;
    t_res             r_out;

    logic [AW-1:0]    from_idx;
    logic [AW-1:0]    to_idx;
    logic             ends_ok;
    logic [CNT_W-1:0] cnt_lim;
    logic             bad_start;
    logic [ROWS-1:0]  cnt_mask;
    logic [ROWS-1:0]  row_rdata;
    logic [ROWS-1:0]  row_val;
    logic [AW-1:0]    row_raddr;
    logic             row_we;
    logic [AW-1:0]    row_waddr;
    logic [ROWS-1:0]  row_wdata;
    logic [AW-1:0]    hi;
    logic             scan_any;
    logic [2*VW-1:0]  stk_rdata;
    logic [2*VW-1:0]  stk_wdata;
    logic             stk_we;
    logic             stk_room;
    logic [FW-1:0]    fill_m1;
    logic [SW-1:0]    stk_raddr;
    logic [AW-1:0]    child_idx;
    logic             hit;
    logic             out_free;
    logic             emit;
    logic             out_load;
    logic             accept;

    assign from_idx = r_in.from_vertex[AW-1:0];
    assign to_idx   = r_in.to_vertex[AW-1:0];
    assign ends_ok  = ({1'b0, r_in.from_vertex} < CNT_W'(ROWS))
                   && ({1'b0, r_in.to_vertex} < CNT_W'(ROWS));
    assign cnt_lim  = (r_vcount > CNT_W'(ROWS)) ? CNT_W'(ROWS) : r_vcount;
    assign bad_start = ({1'b0, r_in.from_vertex} >= cnt_lim);

    always_comb begin
        for (int j = 0; j < ROWS; j++) begin
            cnt_mask[j] = (CNT_W'(j) < r_cnt);
        end
    end

    // highest pending neighbor first
    always_comb begin
        hi = '0;
        for (int j = 0; j < ROWS; j++) begin
            if (r_scan[j]) begin
                hi = AW'(j);
            end
        end
    end
    assign scan_any = |r_scan;

    assign row_val = r_rd_vld ? row_rdata : '0;

    always_comb begin
        case (i_op)
            OP_ADD_RD_F: row_raddr = from_idx;
            OP_ADD_RD_T: row_raddr = to_idx;
            default:     row_raddr = r_cur;
        endcase
    end

    assign row_we    = ((i_op == OP_ADD_WR_F) || (i_op == OP_ADD_WR_T)) && ends_ok;
    assign row_waddr = (i_op == OP_ADD_WR_F) ? from_idx : to_idx;
    assign row_wdata = row_val
                     | (ROWS'(1) << ((i_op == OP_ADD_WR_F) ? to_idx : from_idx));

    dfst_ram #(.WIDTH(ROWS), .DEPTH(ROWS)) u_rows (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // stack entry: {parent, child}; a push onto a full stack is dropped
    assign stk_room  = (r_fill < FW'(STACK_DEPTH));
    assign stk_we    = (i_op == OP_PUSH) && scan_any && stk_room;
    assign stk_wdata = {VW'(r_cur), VW'(hi)};
    assign fill_m1   = r_fill - FW'(1);
    // the fill has already dropped in the check step; keep reading the popped entry
    assign stk_raddr = (i_op == OP_CHECK) ? r_fill[SW-1:0] : fill_m1[SW-1:0];

    dfst_ram #(.WIDTH(2 * VW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_fill[SW-1:0]),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign child_idx = stk_rdata[AW-1:0];
    assign hit       = r_visited[child_idx];
    assign out_free  = !r_out_v || o_res.ready;
    assign emit      = (i_op == OP_CHECK) && !hit && !(r_pend_v && !out_free);
    assign out_load  = (emit && r_pend_v)
                    || (((i_op == OP_FINISH) || (i_op == OP_BAD)) && out_free);

    assign i_cmd.ready = (i_op == OP_FETCH);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;

    always_comb begin
        o_status.hold    = 1'b0;
        o_status.jump    = 1'b0;
        o_status.command = i_cmd.data.command;
        case (i_op)
            OP_FETCH:    o_status.hold = !i_cmd.valid;
            OP_ADD_WR_F: o_status.jump = !r_in.both_ways;
            OP_ADD_WR_T: o_status.jump = 1'b1;
            OP_CLEAR:    o_status.jump = 1'b1;
            OP_TEST:     o_status.jump = bad_start;
            OP_START:    o_status.jump = 1'b1;
            OP_POP:      o_status.jump = (r_fill == '0);
            OP_CHECK: begin
                o_status.jump = hit;
                o_status.hold = !hit && r_pend_v && !out_free;
            end
            OP_PUSH: begin
                o_status.hold = scan_any;
                o_status.jump = 1'b1;
            end
            OP_FINISH, OP_BAD: begin
                o_status.hold = !out_free;
                o_status.jump = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount  <= VCOUNT_RST;
            r_cnt     <= CNT_W'(ROWS);
            r_visited <= '0;
            r_row_vld <= '0;
            r_fill    <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vcount <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
            case (i_op)
                OP_CLEAR: r_row_vld <= '0;
                OP_ADD_WR_F: if (ends_ok) begin
                    r_row_vld[from_idx] <= 1'b1;
                end
                OP_ADD_WR_T: if (ends_ok) begin
                    r_row_vld[to_idx] <= 1'b1;
                end
                OP_TEST: r_cnt <= cnt_lim;
                OP_START: begin
                    r_visited <= ROWS'(1) << from_idx;
                    r_fill    <= '0;
                    r_pend_v  <= 1'b1;
                end
                OP_PUSH: if (stk_we) begin
                    r_fill <= r_fill + FW'(1);
                end
                OP_POP: if (r_fill != '0) begin
                    r_fill <= fill_m1;
                end
                OP_CHECK: if (emit) begin
                    r_visited[child_idx] <= 1'b1;
                    r_pend_v             <= 1'b1;
                end
                OP_FINISH: if (out_free) begin
                    r_pend_v <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_row_vld[row_raddr];
        if (accept) begin
            r_in <= i_cmd.data;
        end
        if (out_load) begin
            case (i_op)
                OP_FINISH: r_out <= '{parent_vertex: r_pend.parent_vertex,
                                      has_parent: r_pend.has_parent,
                                      child_vertex: r_pend.child_vertex,
                                      bad_start: r_pend.bad_start, last: 1'b1};
                OP_BAD:  r_out <= '{parent_vertex: '0, has_parent: 1'b0,
                                    child_vertex: '0, bad_start: 1'b1, last: 1'b1};
                default: r_out <= r_pend;
            endcase
        end
        case (i_op)
            OP_START: begin
                r_cur  <= from_idx;
                r_pend <= '{parent_vertex: '0, has_parent: 1'b0,
                            child_vertex: r_in.from_vertex, bad_start: 1'b0, last: 1'b0};
            end
            OP_CHECK: if (emit) begin
                r_cur  <= child_idx;
                r_pend <= '{parent_vertex: stk_rdata[2*VW-1:VW], has_parent: 1'b1,
                            child_vertex: stk_rdata[VW-1:0], bad_start: 1'b0, last: 1'b0};
            end
            OP_LOAD_ROW: r_scan <= row_val & ~r_visited & cnt_mask;
            OP_PUSH:     r_scan <= r_scan & ~(ROWS'(1) << hi);
            default: ;
        endcase
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(STACK_DEPTH))
        else $error("stack fill beyond depth");

    a_no_held_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_FETCH) |-> !r_pend_v)
        else $error("held result left behind after a run");

    a_visited_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_op == OP_POP) || (i_op == OP_CHECK)) |-> ((r_visited & ~cnt_mask) == '0))
        else $error("visited vertex outside the active count");
endmodule

// ----- rtl/dfs_spanning_tree_matrix.sv -----
// Depth-first spanning-tree search over a bit adjacency matrix, run by a microcoded sequencer.
// An add edge command reads and rewrites the from row, and the to row as well when both_ways
// is set. A run tests the start vertex, then for each visited vertex reads and loads its
// row, pushes each unvisited neighbor within the count, and pops pairs, skipping those whose
// child was already visited; the row memory and stack memory each give one access per cycle,
// and the push scan handles one neighbor per cycle. Results leave through an output register,
// so a waiting result stalls the run only when the next one is ready. The matrix clears at
// reset and on the clear command through per-row valid bits, with no sweep. Depends on
// dfst_pkg, dfst_if, dfst_seq, dfst_dp and dfst_ram.
module dfs_spanning_tree_matrix #(
    parameter int VERTICES    = dfst_pkg::VERTICES_DEF,
    parameter int STACK_DEPTH = dfst_pkg::STACK_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [dfst_pkg::CNT_W-1:0] i_cfg_wr_data,
    dfst_cmd_if.sink                   i_cmd,
    dfst_res_if.source                 o_res
);
    import dfst_pkg::*;

    t_op     op;
    t_status status;

    dfst_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_op     (op)
    );

    dfst_dp #(
        .VERTICES    (VERTICES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op          (op),
        .o_status      (status),
        .i_cmd         (i_cmd),
        .o_res         (o_res)
    );
endmodule

// ----- tb/sv/dfst_tree_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for dfs_spanning_tree_matrix: keeps its own adjacency matrix and vertex count,
// predicts the tree edges of every accepted search and checks each result transfer.
// Depends on dfst_pkg.
module dfst_tree_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [dfst_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  logic                       i_cmd_valid,
    input  logic                       i_cmd_ready,
    input  dfst_pkg::t_cmd             i_cmd_data,
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  dfst_pkg::t_res             i_res_data,
    output int                         o_fail_count,
    output int                         o_edges_due,
    output int                         o_edges_seen
);
    import dfst_pkg::*;

    typedef struct packed {
        logic [VW-1:0] parent;
        logic [VW-1:0] child;
    } t_pair;

    logic [63:0]      adj_rows [64];
    logic [63:0]      visited;
    logic [CNT_W-1:0] vcount;
    t_pair            open_pairs [$];
    t_res             edges_due [$];
    int               misses = 0;
    int               seen_count = 0;

    // scan the row from the top index down, so the lowest neighbor ends up on top
    function automatic void push_unvisited(input logic [VW-1:0] src_v, input int span);
        for (int j = span - 1; j >= 0; j--) begin
            if (adj_rows[src_v][j] && !visited[j] && open_pairs.size() < STACK_DEPTH_DEF)
                open_pairs.push_back('{parent: src_v, child: VW'(j)});
        end
    endfunction

    task automatic predict_search(input logic [VW-1:0] start);
        int    span;
        t_pair pair;
        t_res  r;
        span = (int'(vcount) > VERTICES_DEF) ? VERTICES_DEF : int'(vcount);
        r = '0;
        if (int'(start) >= span) begin
            r.bad_start = 1'b1;
            r.last      = 1'b1;
            edges_due.push_back(r);
            return;
        end
        visited = 64'd1 << start;
        open_pairs.delete();
        r.child_vertex = start;
        edges_due.push_back(r);
        push_unvisited(start, span);
        while (open_pairs.size() > 0) begin
            pair = open_pairs.pop_back();
            if (visited[pair.child])
                continue;
            visited[pair.child] = 1'b1;
            r = '0;
            r.parent_vertex = pair.parent;
            r.has_parent    = 1'b1;
            r.child_vertex  = pair.child;
            edges_due.push_back(r);
            push_unvisited(pair.child, span);
        end
        r = edges_due.pop_back();
        r.last = 1'b1;
        edges_due.push_back(r);
    endtask

    task automatic log_miss(input string what, input t_res want, input t_res got);
        misses++;
        if (misses <= 10) begin
            $write("%0t %s: expected par=%0d hp=%0d child=%0d bad=%0d last=%0d",
                   $realtime, what, want.parent_vertex, want.has_parent, want.child_vertex,
                   want.bad_start, want.last);
            $display(", got par=%0d hp=%0d child=%0d bad=%0d last=%0d",
                     got.parent_vertex, got.has_parent, got.child_vertex, got.bad_start,
                     got.last);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_res want;
        if (!i_rst_n) begin
            foreach (adj_rows[v])
                adj_rows[v] = '0;
            visited = '0;
            vcount  = VCOUNT_RST;
            edges_due.delete();
        end else begin
            // check results before predicting, so a stray result can't match a new search
            if (i_res_valid && i_res_ready) begin
                seen_count++;
                if (edges_due.size() == 0) begin
                    log_miss("unexpected result", '0, i_res_data);
                end else begin
                    want = edges_due.pop_front();
                    if (i_res_data !== want)
                        log_miss("result mismatch", want, i_res_data);
                end
            end
            if (i_cfg_wr_en)
                vcount = i_cfg_wr_data;
            if (i_cmd_valid && i_cmd_ready) begin
                case (i_cmd_data.command)
                    CMD_ADD_EDGE: begin
                        adj_rows[i_cmd_data.from_vertex][i_cmd_data.to_vertex] = 1'b1;
                        if (i_cmd_data.both_ways)
                            adj_rows[i_cmd_data.to_vertex][i_cmd_data.from_vertex] = 1'b1;
                    end
                    CMD_RUN: predict_search(i_cmd_data.from_vertex);
                    CMD_CLEAR: begin
                        foreach (adj_rows[v])
                            adj_rows[v] = '0;
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= misses;
        o_edges_due  <= edges_due.size();
        o_edges_seen <= seen_count;
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Top of the dfs_spanning_tree_matrix testbench: clock, reset, command stimulus, result
// back-pressure and the verdict. Depends on dfst_pkg, dfst_if, dfst_tree_checker, the DUT.
module testbench;
    import dfst_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;

    dfst_cmd_if cmd_ch ();
    dfst_res_if res_ch ();

    int fail_count;
    int edges_due;
    int edges_seen;

    int src_idle_pct  = 13;
    int sink_idle_pct = 70;
    int hold_asked    = 0;
    int hold_served   = 0;
    int vcount_set    = 64;
    int mid_count     = 0;
    int cmds_sent     = 0;
    int searches_sent = 0;

    always #5 i_clk = ~i_clk;

    dfs_spanning_tree_matrix dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_cmd         (cmd_ch),
        .o_res         (res_ch)
    );

    dfst_tree_checker tree_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_cmd_valid   (cmd_ch.valid),
        .i_cmd_ready   (cmd_ch.ready),
        .i_cmd_data    (cmd_ch.data),
        .i_res_valid   (res_ch.valid),
        .i_res_ready   (res_ch.ready),
        .i_res_data    (res_ch.data),
        .o_fail_count  (fail_count),
        .o_edges_due   (edges_due),
        .o_edges_seen  (edges_seen)
    );

    function automatic t_cmd command_word(input logic [1:0] op, input logic [VW-1:0] src_v,
                                          input logic [VW-1:0] dst_v, input logic both);
        t_cmd c;
        c.command     = op;
        c.from_vertex = src_v;
        c.to_vertex   = dst_v;
        c.both_ways   = both;
        return c;
    endfunction

    // returns at the edge where the transfer happened, valid still high
    task automatic send(input t_cmd c);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (c.command != 2'd3)
            cmds_sent++;
        if (c.command == CMD_RUN)
            searches_sent++;
    endtask

    // drain all results, then give trailing edge loads or clears time to finish
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (edges_due != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_count(input int value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(value);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        vcount_set = value;
    endtask

    function automatic logic [VW-1:0] top_vertex();
        return (vcount_set == 0 || vcount_set >= 64) ? VW'(63) : VW'(vcount_set - 1);
    endfunction

    // mostly small graphs on a vertex pool followed by searches, some raw noise
    task automatic random_phase(input int quota);
        logic [VW-1:0] pool [10];
        logic [VW-1:0] a, b;
        int            made;
        int            n;
        logic [1:0]    op;
        made = 0;
        while (made < quota) begin
            if ($urandom_range(9) < 7) begin
                foreach (pool[i])
                    pool[i] = VW'($urandom_range(top_vertex()));
                if ($urandom_range(1)) begin
                    send(command_word(CMD_CLEAR, VW'($urandom), VW'($urandom), 1'($urandom)));
                    made++;
                end
                n = $urandom_range(3, 12);
                repeat (n) begin
                    if ($urandom_range(7) == 0) begin
                        a = VW'($urandom_range(63));
                        b = VW'($urandom_range(63));
                    end else begin
                        a = pool[$urandom_range(9)];
                        b = pool[$urandom_range(9)];
                    end
                    send(command_word(CMD_ADD_EDGE, a, b, 1'($urandom)));
                    made++;
                end
                repeat ($urandom_range(1, 2)) begin
                    a = ($urandom_range(5) == 0) ? VW'($urandom_range(63))
                                                 : pool[$urandom_range(9)];
                    send(command_word(CMD_RUN, a, VW'($urandom), 1'($urandom)));
                    made++;
                end
            end else begin
                op = 2'($urandom_range(3));
                send(command_word(op, VW'($urandom), VW'($urandom), 1'($urandom)));
                if (op != 2'd3)
                    made++;
            end
        end
    endtask

    // receiver: random ready, or a long hold-off when the stimulus asks for one
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                res_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_served++;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("dfs_spanning_tree_matrix verification failed");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty graph, extreme vertices, self loop, a skipped revisit, unused op
        send(command_word(CMD_RUN, 6'd0, 6'd0, 1'b0));
        send(command_word(CMD_ADD_EDGE, 6'd0, 6'd63, 1'b1));
        send(command_word(CMD_ADD_EDGE, 6'd63, 6'd62, 1'b0));
        send(command_word(CMD_ADD_EDGE, 6'd5, 6'd5, 1'b1));
        send(command_word(CMD_ADD_EDGE, 6'd62, 6'd0, 1'b0));
        send(command_word(CMD_RUN, 6'd0, 6'd63, 1'b1));
        send(command_word(CMD_RUN, 6'd62, 6'd0, 1'b0));
        send(command_word(CMD_RUN, 6'd5, 6'd0, 1'b0));
        send(command_word(CMD_ADD_EDGE, 6'd10, 6'd20, 1'b1));
        send(command_word(CMD_ADD_EDGE, 6'd10, 6'd30, 1'b1));
        send(command_word(CMD_ADD_EDGE, 6'd10, 6'd15, 1'b0));
        send(command_word(CMD_ADD_EDGE, 6'd20, 6'd30, 1'b0));
        send(command_word(CMD_RUN, 6'd10, 6'd0, 1'b0));
        send(command_word(2'd3, 6'd63, 6'd63, 1'b1));
        send(command_word(CMD_RUN, 6'd63, 6'd0, 1'b0));
        send(command_word(CMD_CLEAR, 6'd0, 6'd0, 1'b0));
        send(command_word(CMD_RUN, 6'd63, 6'd0, 1'b0));
        // zero count: every start is out of range
        write_count(0);
        send(command_word(CMD_RUN, 6'd0, 6'd0, 1'b0));
        send(command_word(CMD_RUN, 6'd63, 6'd0, 1'b0));
        // single vertex: edge beyond the count is stored but never reached
        write_count(1);
        send(command_word(CMD_ADD_EDGE, 6'd0, 6'd1, 1'b1));
        send(command_word(CMD_RUN, 6'd0, 6'd0, 1'b0));
        send(command_word(CMD_RUN, 6'd1, 6'd0, 1'b0));
        // oversized count saturates to the matrix size
        write_count(127);
        send(command_word(CMD_ADD_EDGE, 6'd63, 6'd0, 1'b1));
        send(command_word(CMD_RUN, 6'd63, 6'd0, 1'b0));

        mid_count = $urandom_range(8, 63);
        write_count(mid_count);
        random_phase(50);

        src_idle_pct  = 70;
        sink_idle_pct = 13;
        write_count(64);
        random_phase(50);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_count(127);
        // results back up behind a long receiver stall while a chain graph is searched
        hold_asked++;
        send(command_word(CMD_CLEAR, 6'd0, 6'd0, 1'b0));
        for (int k = 0; k < 12; k++)
            send(command_word(CMD_ADD_EDGE, VW'(k), VW'(k + 1), 1'b1));
        send(command_word(CMD_RUN, 6'd0, 6'd0, 1'b0));
        send(command_word(CMD_RUN, 6'd6, 6'd0, 1'b0));
        send(command_word(CMD_RUN, 6'd12, 6'd0, 1'b0));
        random_phase(50);

        settle();
        $display("Covered %0d commands with %0d searches and %0d tree edges checked,",
                 cmds_sent, searches_sent, edges_seen);
        $display("vertex counts 0, 1, %0d, 64, 127, three idle profiles and a result stall.",
                 mid_count);
        if (fail_count == 0 && edges_due == 0)
            $display("dfs_spanning_tree_matrix verification clean");
        else
            $display("dfs_spanning_tree_matrix verification failed");
        $finish;
    end

endmodule
